### design/http2_frame_deframer_unit_macros.svh
// Assertion macros shared by the deframer checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef HTTP2_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define HTTP2_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hfd_pkg.sv
// Types and constants for the HTTP/2 frame deframer.
// Used by the channel interfaces, the top level and its checker.
`default_nettype none

package hfd_pkg;

  localparam logic [3:0]  HDR_BYTES   = 4'd9;
  localparam logic [7:0]  MAX_KIND    = 8'd9;
  localparam logic [24:0] LIMIT_RESET = 25'd16393;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_KIND  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STATUS_HALTED    = 2'd3;

  // Register word index, taken from the word address bit of paddr.
  localparam logic REG_FRAME_LIMIT = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_header;
    logic        frame_begin;
    logic        header_done;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_flags;
    logic [30:0] stream_number;
    logic [23:0] payload_length;
    logic        frame_end;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

### design/hfd_if.sv
// Valid/ready channel interfaces for the deframer's byte input and tagged output.
// Depends on hfd_pkg for the payload types.
`default_nettype none

interface hfd_byte_if;
  logic              valid;
  logic              ready;
  hfd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfd_frame_if;
  logic               valid;
  logic               ready;
  hfd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/http2_frame_deframer_unit.sv
// HTTP/2 frame deframer. Takes one stream byte per request and returns one tagged
// byte per request from a result register; a new byte is taken
// every cycle, and bytes stop only while a finished result waits for the sink.
// Header capture, payload counting and the size and type checks are all done
// combinationally, between the input handshake and the result register. An error
// halts the block until reset. frame_limit is written through the APB port.
`default_nettype none

module http2_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  hfd_byte_if.sink         bytes,
  hfd_frame_if.source      frames
);
  import hfd_pkg::*;

  logic [24:0] frame_limit;
  logic [3:0]  header_count, header_count_next;
  logic [23:0] length_field, length_field_next;
  logic [7:0]  kind_field, kind_field_next;
  logic [7:0]  flags_field, flags_field_next;
  logic [30:0] stream_field, stream_field_next;
  logic [23:0] payload_left, payload_left_next;
  logic        halted, halted_next;

  logic        out_valid;
  out_item_t   out_data;
  out_item_t   result;
  logic        accept;
  logic        cfg_write;
  logic [24:0] frame_total;
  logic [7:0]  b;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAME_LIMIT);
  assign prdata    = (paddr[2] == REG_FRAME_LIMIT) ? {7'd0, frame_limit} : 32'd0;

  assign bytes.ready  = !out_valid || frames.ready;
  assign accept       = bytes.valid && bytes.ready;
  assign frames.valid = out_valid;
  assign frames.data  = out_data;
  assign b            = bytes.data.data_byte;

  assign frame_total = {1'b0, length_field_next} + {21'd0, HDR_BYTES};

  always_comb begin
    header_count_next = header_count;
    length_field_next = length_field;
    kind_field_next   = kind_field;
    flags_field_next  = flags_field;
    stream_field_next = stream_field;
    payload_left_next = payload_left;
    halted_next       = halted;
    result            = '0;
    result.out_byte   = b;
    result.status     = STATUS_OK;

    if (halted) begin
      result.status = STATUS_HALTED;
    end else if (header_count < HDR_BYTES) begin
      result.in_header  = 1'b1;
      header_count_next = header_count + 4'd1;
      case (header_count)
        4'd0: begin
          result.frame_begin = 1'b1;
          length_field_next  = {b, 16'd0};
          kind_field_next    = '0;
          flags_field_next   = '0;
          stream_field_next  = '0;
        end
        4'd1: length_field_next[15:8] = b;
        4'd2: length_field_next[7:0]  = b;
        4'd3: kind_field_next         = b;
        4'd4: flags_field_next        = b;
        default: stream_field_next    = {stream_field[22:0], b};
      endcase
      // The ninth header byte closes the header and runs both checks.
      if (header_count_next == HDR_BYTES) begin
        result.header_done = 1'b1;
        if (frame_total > frame_limit) begin
          result.status = STATUS_TOO_LARGE;
          halted_next   = 1'b1;
        end else if (kind_field_next > MAX_KIND) begin
          result.status = STATUS_BAD_KIND;
          halted_next   = 1'b1;
        end else if (length_field_next == 24'd0) begin
          result.frame_end  = 1'b1;
          header_count_next = 4'd0;
        end else begin
          payload_left_next = length_field_next;
        end
      end
    end else begin
      if (payload_left <= 24'd1) begin
        result.frame_end  = 1'b1;
        payload_left_next = '0;
        header_count_next = 4'd0;
      end else begin
        payload_left_next = payload_left - 24'd1;
      end
    end

    result.frame_kind     = kind_field_next;
    result.frame_flags    = flags_field_next;
    result.stream_number  = stream_field_next;
    result.payload_length = length_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit  <= LIMIT_RESET;
      header_count <= '0;
      length_field <= '0;
      kind_field   <= '0;
      flags_field  <= '0;
      stream_field <= '0;
      payload_left <= '0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        frame_limit <= pwdata[24:0];
      end
      if (accept) begin
        header_count <= header_count_next;
        length_field <= length_field_next;
        kind_field   <= kind_field_next;
        flags_field  <= flags_field_next;
        stream_field <= stream_field_next;
        payload_left <= payload_left_next;
        halted       <= halted_next;
        out_valid    <= 1'b1;
      end else if (frames.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### design/hfd_checker.sv
// Port-level checker for the deframer and the bind that attaches it.
// Depends on hfd_pkg and http2_frame_deframer_unit_macros.svh.
`default_nettype none

`include "http2_frame_deframer_unit_macros.svh"

module hfd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hfd_pkg::out_item_t out_data
);
  import hfd_pkg::*;

  logic out_accept;
  logic in_accept;
  logic err_seen;
  logic after_err;
  logic shows_halt;
  logic stalled;
  logic empty_hdr;

  assign out_accept = out_valid && out_ready;
  assign in_accept  = in_valid && in_ready;
  assign after_err  = out_valid && err_seen;
  assign shows_halt = (out_data.status == STATUS_HALTED);
  assign stalled    = out_valid && !out_ready;
  assign empty_hdr  = out_valid && out_data.header_done && out_data.status == STATUS_OK &&
                      out_data.payload_length == 24'd0;

  // Remembers that an error result has been delivered since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (out_accept && (out_data.status == STATUS_BAD_KIND ||
                                out_data.status == STATUS_TOO_LARGE)) begin
      err_seen <= 1'b1;
    end
  end

  `HFD_ASSERT_NOW(a_halt_sticky, clk, rst, after_err, shows_halt, "halt is not sticky")
  `HFD_ASSERT_NOW(a_ready_only_on_stall, clk, rst, !in_ready, stalled, "needless input stall")
  `HFD_ASSERT_NOW(a_empty_ends, clk, rst, empty_hdr, out_data.frame_end, "empty frame not ended")
  `HFD_ASSERT_NEXT(a_hold, clk, rst, stalled, out_valid && $stable(out_data), "result changed")
  `HFD_ASSERT_NEXT(a_accept_fills, clk, rst, in_accept, out_valid, "request lost")

endmodule

bind http2_frame_deframer_unit hfd_checker u_hfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .out_valid (frames.valid),
  .out_ready (frames.ready),
  .out_data  (frames.data)
);

`default_nettype wire
